FILE: rtl/bbps_pkg.sv
// Shared package of the bounded bit-pattern search block.
// Holds constants, controller/datapath types and double-precision helpers.
// Depends on nothing.
`default_nettype none
package bbps_pkg;

	localparam int MAX_STEPS_DEF = 8;

	localparam logic [63:0] SIGN_BIT    = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MAG_MASK    = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] ALL_ONES    = 64'hffff_ffff_ffff_ffff;
	localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;
	localparam logic [63:0] DEFAULT_NAN = 64'hfff8_0000_0000_0000;

	localparam logic CFG_ERROR_BOUND   = 1'b0;
	localparam logic CFG_ADJUST_OFFSET = 1'b1;

	typedef enum logic [1:0] {
		CASE_POS,
		CASE_NEG,
		CASE_CROSS,
		CASE_NAN
	} bbps_case_t;

	typedef enum logic [1:0] {
		FSEL_FALLBACK,
		FSEL_SUB_ADJ,
		FSEL_SUB_VAL
	} bbps_fsel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FB_GO,
		ST_FB_WAIT,
		ST_CLASSIFY,
		ST_SCAN,
		ST_INIT,
		ST_STEP,
		ST_RANGE,
		ST_SUB1,
		ST_SUB1_WAIT,
		ST_SUB2,
		ST_SUB2_WAIT,
		ST_EVAL,
		ST_MISS,
		ST_SEARCH_END,
		ST_FINISH
	} bbps_state_t;

	typedef struct packed {
		logic       load_item;
		logic       fadd_start;
		bbps_fsel_t fsel;
		logic       cap_fb;
		logic       setup;
		logic       second;
		logic       scan_step;
		logic       init_loop;
		logic       set_cand1;
		logic       set_cand2;
		logic       cap_diff;
		logic       next_step;
		logic       res_cand;
		logic       res_fb;
		logic       out_load;
	} bbps_cmd_t;

	typedef struct packed {
		bbps_case_t item_case;
		logic       scan_last;
		logic       range_ok;
		logic       within_ok;
		logic       steps_done;
		logic       cand_is2;
		logic       res_eq_fb;
		logic       fadd_done;
		logic       out_free;
	} bbps_sts_t;

	function automatic logic is_nan(input logic [63:0] x);
		return (x[62:52] == 11'h7ff) && (x[51:0] != 52'd0);
	endfunction

	function automatic logic is_zero(input logic [63:0] x);
		return x[62:0] == 63'd0;
	endfunction

	// Ordered less-or-equal of two doubles; false when either is NaN.
	function automatic logic fp_le(input logic [63:0] a, input logic [63:0] b);
		logic r;
		r = 1'b0;
		if (is_nan(a) || is_nan(b)) begin
			r = 1'b0;
		end else if (is_zero(a) && is_zero(b)) begin
			r = 1'b1;
		end else if (a[63] != b[63]) begin
			r = a[63];
		end else if (!a[63]) begin
			r = a[62:0] <= b[62:0];
		end else begin
			r = a[62:0] >= b[62:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/bbps_fadd.sv
// Pipelined double-precision adder/subtractor, round to nearest even.
// Handles zeros, subnormals, infinities and NaN propagation. Uses bbps_pkg.
`default_nettype none
module bbps_fadd (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	input  wire logic        sub,
	output logic             done,
	output logic      [63:0] sum
);
	import bbps_pkg::*;

	function automatic logic [5:0] clz56(input logic [55:0] v);
		logic [5:0] n;
		logic       f;
		n = 6'd56;
		f = 1'b0;
		for (int i = 55; i >= 0; i--) begin
			if (!f && v[i]) begin
				n = 6'(55 - i);
				f = 1'b1;
			end
		end
		return n;
	endfunction

	logic [63:0] bn, x, y, spres;
	logic        spc, swap;
	logic [10:0] ex, ey, d;
	logic [55:0] mx, my, my_al;

	always_comb begin
		bn = sub ? (b ^ SIGN_BIT) : b;
		spc = 1'b1;
		spres = DEFAULT_NAN;
		if (is_nan(a)) begin
			spres = a | QUIET_BIT;
		end else if (is_nan(b)) begin
			spres = b | QUIET_BIT;
		end else if (a[62:0] == {11'h7ff, 52'd0} && bn[62:0] == {11'h7ff, 52'd0}
				&& a[63] != bn[63]) begin
			spres = DEFAULT_NAN;
		end else if (a[62:0] == {11'h7ff, 52'd0}) begin
			spres = a;
		end else if (bn[62:0] == {11'h7ff, 52'd0}) begin
			spres = bn;
		end else begin
			spc = 1'b0;
		end
		swap = bn[62:0] > a[62:0];
		x = swap ? bn : a;
		y = swap ? a : bn;
		ex = (x[62:52] == 11'd0) ? 11'd1 : x[62:52];
		ey = (y[62:52] == 11'd0) ? 11'd1 : y[62:52];
		mx = {x[62:52] != 11'd0, x[51:0], 3'b000};
		my = {y[62:52] != 11'd0, y[51:0], 3'b000};
		d = ex - ey;
		if (d >= 11'd56) begin
			my_al = {55'd0, |my};
		end else begin
			my_al = (my >> d[5:0]) | {55'd0, |(my & ~({56{1'b1}} << d[5:0]))};
		end
	end

	logic        v_s1, spc_s1, sign_s1, zsign_s1, sub_s1;
	logic [63:0] spres_s1;
	logic [11:0] exp_s1;
	logic [55:0] mx_s1, my_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		spc_s1 <= spc;
		spres_s1 <= spres;
		sign_s1 <= x[63];
		zsign_s1 <= (x[63] ^ y[63]) ? 1'b0 : x[63];
		sub_s1 <= x[63] ^ y[63];
		exp_s1 <= {1'b0, ex};
		mx_s1 <= mx;
		my_s1 <= my_al;
	end

	logic        v_s2, spc_s2, sign_s2, zsign_s2;
	logic [63:0] spres_s2;
	logic [11:0] exp_s2;
	logic [56:0] sum_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		spc_s2 <= spc_s1;
		spres_s2 <= spres_s1;
		sign_s2 <= sign_s1;
		zsign_s2 <= zsign_s1;
		exp_s2 <= exp_s1;
		sum_s2 <= sub_s1 ? ({1'b0, mx_s1} - {1'b0, my_s1}) : ({1'b0, mx_s1} + {1'b0, my_s1});
	end

	logic [5:0]  lz, sh;
	logic [11:0] maxsh, e3;
	logic [55:0] m3;

	always_comb begin
		lz = clz56(sum_s2[55:0]);
		maxsh = exp_s2 - 12'd1;
		sh = ({6'd0, lz} < maxsh) ? lz : maxsh[5:0];
		if (sum_s2[56]) begin
			m3 = {sum_s2[56:2], sum_s2[1] | sum_s2[0]};
			e3 = exp_s2 + 12'd1;
		end else begin
			m3 = sum_s2[55:0] << sh;
			e3 = exp_s2 - {6'd0, sh};
		end
	end

	logic        v_s3, spc_s3, sign_s3, zsign_s3, zero_s3;
	logic [63:0] spres_s3;
	logic [11:0] e_s3;
	logic [55:0] m_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		spc_s3 <= spc_s2;
		spres_s3 <= spres_s2;
		sign_s3 <= sign_s2;
		zsign_s3 <= zsign_s2;
		zero_s3 <= sum_s2 == 57'd0;
		e_s3 <= e3;
		m_s3 <= m3;
	end

	logic        up;
	logic [53:0] mr;
	logic [52:0] mn;
	logic [11:0] en;
	logic [63:0] res;

	always_comb begin
		up = m_s3[2] & (m_s3[1] | m_s3[0] | m_s3[3]);
		mr = {1'b0, m_s3[55:3]} + {53'd0, up};
		mn = mr[53] ? mr[53:1] : mr[52:0];
		en = mr[53] ? (e_s3 + 12'd1) : e_s3;
		if (spc_s3) begin
			res = spres_s3;
		end else if (zero_s3) begin
			res = {zsign_s3, 63'd0};
		end else if (en >= 12'd2047) begin
			res = {sign_s3, 11'h7ff, 52'd0};
		end else begin
			res = {sign_s3, mn[52] ? en[10:0] : 11'd0, mn[51:0]};
		end
	end

	logic v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		sum <= res;
	end

	assign done = v_s4;

endmodule
`default_nettype wire

FILE: rtl/bbps_dp.sv
// Datapath of the bounded bit-pattern search: item, configuration, search registers,
// output register and the shared double adder. Uses bbps_pkg and bbps_fadd.
`default_nettype none
module bbps_dp #(
	parameter int MAX_SEARCH_STEPS = bbps_pkg::MAX_STEPS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire bbps_pkg::bbps_cmd_t cmd,
	output bbps_pkg::bbps_sts_t      sts,
	input  wire logic                cfg_we,
	input  wire logic                cfg_index,
	input  wire logic [63:0]         cfg_data,
	input  wire logic [63:0]         range_low,
	input  wire logic [63:0]         range_high,
	input  wire logic [63:0]         sample_value,
	input  wire logic [63:0]         previous_pattern,
	input  wire logic                out_ready,
	output logic                     out_valid,
	output logic [63:0]              approx_pattern
);
	import bbps_pkg::*;

	localparam int STEP_W = $clog2(MAX_SEARCH_STEPS + 1);
	localparam logic [7:0] MAX_STEPS = 8'(MAX_SEARCH_STEPS);

	function automatic logic [3:0] clz8(input logic [7:0] v);
		logic [3:0] n;
		logic       f;
		n = 4'd8;
		f = 1'b0;
		for (int i = 7; i >= 0; i--) begin
			if (!f && v[i]) begin
				n = 4'(7 - i);
				f = 1'b1;
			end
		end
		return n;
	endfunction

	logic [63:0] bound_q, adj_q;
	logic [63:0] rlo_q, rhi_q, val_q, prev_q, fb_q;
	logic [63:0] lo_q, hi_q, x_q, mask_q, cand_q, diff_q, res_q;
	logic        sign_q, is2_q, ovalid_q;
	logic [6:0]  lz_q, shift_q;
	logic [2:0]  bcnt_q;
	logic [STEP_W-1:0] steps_q;
	logic [63:0] approx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_q <= '0;
			adj_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ERROR_BOUND:   bound_q <= cfg_data;
				CFG_ADJUST_OFFSET: adj_q <= cfg_data;
			endcase
		end
	end

	bbps_case_t item_case;
	logic       lo_nan, hi_nan, lo_zero, hi_zero;

	always_comb begin
		lo_nan = is_nan(rlo_q);
		hi_nan = is_nan(rhi_q);
		lo_zero = is_zero(rlo_q);
		hi_zero = is_zero(rhi_q);
		if (!lo_nan && (!rlo_q[63] || lo_zero)) begin
			item_case = CASE_POS;
		end else if (!hi_nan && (rhi_q[63] || hi_zero)) begin
			item_case = CASE_NEG;
		end else if (!lo_nan && !hi_nan) begin
			item_case = CASE_CROSS;
		end else begin
			item_case = CASE_NAN;
		end
	end

	logic [63:0] setup_lo, setup_hi;
	logic        setup_sign;

	always_comb begin
		setup_lo = rlo_q;
		setup_hi = rhi_q;
		setup_sign = 1'b0;
		if (cmd.second) begin
			setup_lo = '0;
			setup_hi = rlo_q ^ SIGN_BIT;
			setup_sign = 1'b1;
		end else begin
			unique case (item_case)
				CASE_NEG: begin
					setup_lo = rhi_q ^ SIGN_BIT;
					setup_hi = rlo_q ^ SIGN_BIT;
					setup_sign = 1'b1;
				end
				CASE_CROSS: begin
					setup_lo = '0;
				end
				CASE_POS, CASE_NAN: begin
					setup_lo = rlo_q;
				end
			endcase
		end
	end

	logic [6:0]  shift_n;
	logic [7:0]  steps_lim;
	logic [63:0] weight, cand1, cand2;

	always_comb begin
		shift_n = 7'd64 - lz_q;
		steps_lim = ({1'b0, shift_n} + 8'd1 < MAX_STEPS) ? ({1'b0, shift_n} + 8'd1) : MAX_STEPS;
		weight = shift_q[6] ? 64'd0 : (64'd1 << shift_q[5:0]);
		cand1 = (lo_q & mask_q) | (prev_q & ~mask_q);
		cand2 = (cand_q + weight) & MAG_MASK;
	end

	logic [63:0] fa, fb_op, fsum;
	logic        fsub, fdone;

	always_comb begin
		fa = val_q;
		fb_op = adj_q;
		fsub = 1'b0;
		unique case (cmd.fsel)
			FSEL_FALLBACK: begin
				fa = val_q;
				fb_op = adj_q;
				fsub = 1'b0;
			end
			FSEL_SUB_ADJ: begin
				fa = cand_q ^ {sign_q, 63'd0};
				fb_op = adj_q;
				fsub = 1'b1;
			end
			FSEL_SUB_VAL: begin
				fa = diff_q;
				fb_op = val_q;
				fsub = 1'b1;
			end
			default: begin
				fa = val_q;
				fb_op = adj_q;
				fsub = 1'b0;
			end
		endcase
	end

	bbps_fadd u_fadd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.fadd_start),
		.a      (fa),
		.b      (fb_op),
		.sub    (fsub),
		.done   (fdone),
		.sum    (fsum)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			rlo_q <= range_low;
			rhi_q <= range_high;
			val_q <= sample_value;
			prev_q <= previous_pattern;
		end
		if (cmd.cap_fb) begin
			fb_q <= fsum;
		end
		if (cmd.setup) begin
			lo_q <= setup_lo & MAG_MASK;
			hi_q <= setup_hi;
			sign_q <= setup_sign;
			x_q <= (setup_lo & MAG_MASK) ^ setup_hi;
			lz_q <= '0;
			bcnt_q <= '0;
		end
		if (cmd.scan_step) begin
			bcnt_q <= bcnt_q + 3'd1;
			if (x_q[63:56] != 8'd0) begin
				lz_q <= lz_q + {3'd0, clz8(x_q[63:56])};
			end else begin
				lz_q <= lz_q + 7'd8;
				x_q <= x_q << 8;
			end
		end
		if (cmd.init_loop) begin
			shift_q <= shift_n;
			mask_q <= shift_n[6] ? 64'd0 : (ALL_ONES << shift_n[5:0]);
			steps_q <= STEP_W'(steps_lim);
		end
		if (cmd.next_step) begin
			mask_q <= {mask_q[63], mask_q[63:1]};
			shift_q <= shift_q - 7'd1;
			steps_q <= steps_q - STEP_W'(1);
		end
		if (cmd.set_cand1) begin
			cand_q <= cand1;
			is2_q <= 1'b0;
		end
		if (cmd.set_cand2) begin
			cand_q <= cand2;
			is2_q <= 1'b1;
		end
		if (cmd.cap_diff) begin
			diff_q <= fsum;
		end
		if (cmd.res_cand) begin
			res_q <= cand_q ^ {sign_q, 63'd0};
		end
		if (cmd.res_fb) begin
			res_q <= fb_q;
		end
		if (cmd.out_load) begin
			approx_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_comb begin
		sts.item_case = item_case;
		sts.scan_last = (x_q[63:56] != 8'd0) || (bcnt_q == 3'd7);
		sts.range_ok = is2_q ? (cand_q <= hi_q) : ((cand_q >= lo_q) && (cand_q <= hi_q));
		sts.within_ok = fp_le(bound_q ^ SIGN_BIT, diff_q) && fp_le(diff_q, bound_q);
		sts.steps_done = steps_q == '0;
		sts.cand_is2 = is2_q;
		sts.res_eq_fb = res_q == fb_q;
		sts.fadd_done = fdone;
		sts.out_free = !ovalid_q || out_ready;
	end

	assign out_valid = ovalid_q;
	assign approx_pattern = approx_q;

endmodule
`default_nettype wire

FILE: rtl/bbps_ctrl.sv
// Controller state machine of the bounded bit-pattern search.
// Sequences the fallback add, the sign-split searches and result delivery. Uses bbps_pkg.
`default_nettype none
module bbps_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire bbps_pkg::bbps_sts_t sts,
	output bbps_pkg::bbps_cmd_t      cmd
);
	import bbps_pkg::*;

	bbps_state_t state_q, state_n;
	logic        second_q, second_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			second_q <= 1'b0;
		end else begin
			state_q <= state_n;
			second_q <= second_n;
		end
	end

	always_comb begin
		state_n = state_q;
		second_n = second_q;
		cmd = '0;
		cmd.fsel = FSEL_FALLBACK;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_n = ST_FB_GO;
				end
			end
			ST_FB_GO: begin
				cmd.fadd_start = 1'b1;
				cmd.fsel = FSEL_FALLBACK;
				state_n = ST_FB_WAIT;
			end
			ST_FB_WAIT: begin
				if (sts.fadd_done) begin
					cmd.cap_fb = 1'b1;
					state_n = ST_CLASSIFY;
				end
			end
			ST_CLASSIFY: begin
				second_n = 1'b0;
				if (sts.item_case == CASE_NAN) begin
					cmd.res_fb = 1'b1;
					state_n = ST_FINISH;
				end else begin
					cmd.setup = 1'b1;
					state_n = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_n = ST_INIT;
				end
			end
			ST_INIT: begin
				cmd.init_loop = 1'b1;
				state_n = ST_STEP;
			end
			ST_STEP: begin
				if (sts.steps_done) begin
					cmd.res_fb = 1'b1;
					state_n = ST_SEARCH_END;
				end else begin
					cmd.set_cand1 = 1'b1;
					state_n = ST_RANGE;
				end
			end
			ST_RANGE: begin
				state_n = sts.range_ok ? ST_SUB1 : ST_MISS;
			end
			ST_SUB1: begin
				cmd.fadd_start = 1'b1;
				cmd.fsel = FSEL_SUB_ADJ;
				state_n = ST_SUB1_WAIT;
			end
			ST_SUB1_WAIT: begin
				if (sts.fadd_done) begin
					cmd.cap_diff = 1'b1;
					state_n = ST_SUB2;
				end
			end
			ST_SUB2: begin
				cmd.fadd_start = 1'b1;
				cmd.fsel = FSEL_SUB_VAL;
				state_n = ST_SUB2_WAIT;
			end
			ST_SUB2_WAIT: begin
				if (sts.fadd_done) begin
					cmd.cap_diff = 1'b1;
					state_n = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (sts.within_ok) begin
					cmd.res_cand = 1'b1;
					state_n = ST_SEARCH_END;
				end else begin
					state_n = ST_MISS;
				end
			end
			ST_MISS: begin
				if (sts.cand_is2) begin
					cmd.next_step = 1'b1;
					state_n = ST_STEP;
				end else begin
					cmd.set_cand2 = 1'b1;
					state_n = ST_RANGE;
				end
			end
			ST_SEARCH_END: begin
				if (!second_q && sts.item_case == CASE_CROSS && sts.res_eq_fb) begin
					cmd.setup = 1'b1;
					cmd.second = 1'b1;
					second_n = 1'b1;
					state_n = ST_SCAN;
				end else begin
					state_n = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_n = ST_IDLE;
				end
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/bounded_bit_pattern_search_top.sv
// Bounded bit-pattern search: for each request, an interval, a value and a
// previous pattern go in; one chosen 64-bit double pattern comes out.
// The input channel (in_valid/in_ready) takes one request at a time. in_ready
// is high only while the block is idle; it drops for the whole search.
// Configuration: cfg_we writes cfg_data into error_bound (index 0) or
// adjust_offset (index 1) in the same cycle; write only while idle.
// Per request: the fallback add and classification, then per search (none
// when classification marks the interval NaN, one, or two when it crosses
// zero and the first search yields the fallback result) a prefix scan, a
// setup step, then per step up to two candidates, each either out of range
// or put through the error check (two subtractions on the shared double
// adder), and a step to close the search. The output register is loaded last.
// The result sits in an output register (out_valid/out_ready). A new request is
// accepted while a result waits; if the next result is ready before the receiver
// takes the old one, the block holds it until the output register frees.
// Reset clears the configuration registers to zero and empties the block.
`default_nettype none
module bounded_bit_pattern_search_top #(
	parameter int MAX_SEARCH_STEPS = bbps_pkg::MAX_STEPS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [63:0] range_low,
	input  wire logic [63:0] range_high,
	input  wire logic [63:0] sample_value,
	input  wire logic [63:0] previous_pattern,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      approx_pattern
);
	import bbps_pkg::*;

	bbps_cmd_t cmd;
	bbps_sts_t sts;

	bbps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bbps_dp #(
		.MAX_SEARCH_STEPS (MAX_SEARCH_STEPS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.range_low        (range_low),
		.range_high       (range_high),
		.sample_value     (sample_value),
		.previous_pattern (previous_pattern),
		.out_ready        (out_ready),
		.out_valid        (out_valid),
		.approx_pattern   (approx_pattern)
	);

endmodule
`default_nettype wire

FILE: rtl/bbps_checker.sv
// Port-level checker of the bounded bit-pattern search, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module bbps_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [63:0] approx_pattern
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("Result dropped before it was taken.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(approx_pattern))
		else $error("Result changed while stalled.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("Second request accepted while a search runs.");

	a_idle_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("New result appeared while the block was still busy.");

endmodule

bind bounded_bit_pattern_search_top bbps_checker u_bbps_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.approx_pattern (approx_pattern)
);
`default_nettype wire

FILE: verif/tb.sv
// Testbench of the bounded bit-pattern search block: directed table, then random requests.
// A double-precision predictor checks every result but those of typed table rows, which carry their own
// expected pattern; random gaps on both channels. Depends on rtl/bbps_pkg.sv and rtl/bounded_bit_pattern_search_top.sv.
`default_nettype none
module tb;
	import bbps_pkg::*;

	localparam int SEARCH_STEPS = MAX_STEPS_DEF;
	localparam int STALL_LIMIT = 20000;
	localparam int PHASE_COUNT = 12;
	localparam int PHASE_ITEMS = 130;

	typedef struct {
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] val;
		logic [63:0] prev;
		bit          typed;
		logic [63:0] result;
	} probe_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [63:0] range_low;
	logic [63:0] range_high;
	logic [63:0] sample_value;
	logic [63:0] previous_pattern;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] approx_pattern;

	logic [63:0] bound_bits;
	logic [63:0] offset_bits;
	logic [63:0] pending_patterns[$];
	int          fails;
	int          quiet_cycles;
	bit          no_idle;
	bit          phase_open;

	bounded_bit_pattern_search_top #(.MAX_SEARCH_STEPS(SEARCH_STEPS)) dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
		.range_low(range_low), .range_high(range_high), .sample_value(sample_value),
		.previous_pattern(previous_pattern), .out_valid(out_valid),
		.out_ready(out_ready), .approx_pattern(approx_pattern)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit near_value(logic [63:0] cand, real val, real adj, real bound);
		real d;
		d = ($bitstoreal(cand) - adj) - val;
		return d >= -bound && d <= bound;
	endfunction

	function automatic logic [63:0] prefix_search(logic [63:0] lo_bits, logic [63:0] hi,
			logic [63:0] sign, real val, logic [63:0] prev, real bound, real adj);
		logic [63:0] lo;
		logic [63:0] x;
		logic [63:0] mask;
		logic [63:0] cand;
		logic [63:0] weight;
		int lz;
		int shift;
		int steps;
		lo = lo_bits & MAG_MASK;
		x = lo ^ hi;
		lz = 0;
		while (lz < 64 && !x[63]) begin
			x = x << 1;
			lz++;
		end
		shift = 64 - lz;
		mask = (shift >= 64) ? 64'd0 : (ALL_ONES << shift);
		steps = (SEARCH_STEPS < shift + 1) ? SEARCH_STEPS : shift + 1;
		for (int i = 0; i < steps && shift >= 0; i++) begin
			cand = (lo & mask) | (prev & ~mask);
			weight = (shift < 64) ? (64'd1 << shift) : 64'd0;
			if (cand >= lo && cand <= hi && near_value(cand ^ sign, val, adj, bound)) begin
				return cand ^ sign;
			end
			cand = (cand + weight) & MAG_MASK;
			if (cand <= hi && near_value(cand ^ sign, val, adj, bound)) begin
				return cand ^ sign;
			end
			mask = (mask >> 1) | (mask & SIGN_BIT);
			shift--;
		end
		return $realtobits(val + adj);
	endfunction

	function automatic logic [63:0] predict_pattern(logic [63:0] lo_bits, logic [63:0] hi_bits,
			logic [63:0] val_bits, logic [63:0] prev);
		real lo;
		real hi;
		real val;
		real bound;
		real adj;
		logic [63:0] fallback;
		logic [63:0] r;
		lo = $bitstoreal(lo_bits);
		hi = $bitstoreal(hi_bits);
		val = $bitstoreal(val_bits);
		bound = $bitstoreal(bound_bits);
		adj = $bitstoreal(offset_bits);
		fallback = $realtobits(val + adj);
		if (lo >= 0.0) begin
			r = prefix_search(lo_bits, hi_bits, 64'd0, val, prev, bound, adj);
		end else if (hi <= 0.0) begin
			r = prefix_search($realtobits(-hi), $realtobits(-lo), SIGN_BIT, val, prev, bound, adj);
		end else if (lo < 0.0 && hi >= 0.0) begin
			r = prefix_search(64'd0, hi_bits, 64'd0, val, prev, bound, adj);
			if (r == fallback) begin
				r = prefix_search(64'd0, $realtobits(-lo), SIGN_BIT, val, prev, bound, adj);
			end
		end else begin
			r = fallback;
		end
		return r;
	endfunction

	function automatic int idle_gap();
		int p;
		p = $urandom_range(0, 99);
		if (no_idle || p < 55) begin
			return 0;
		end else if (p < 88) begin
			return $urandom_range(1, 3);
		end else if (p < 98) begin
			return $urandom_range(4, 15);
		end
		return $urandom_range(30, 100);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic write_reg(logic idx, logic [63:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx == CFG_ERROR_BOUND) begin
			bound_bits = data;
		end else begin
			offset_bits = data;
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		@(posedge clk);
		in_valid <= 1'b0;
		while (pending_patterns.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
	endtask

	task automatic send_request(logic [63:0] lo, logic [63:0] hi, logic [63:0] val,
			logic [63:0] prev, bit typed, logic [63:0] result);
		int gap;
		gap = idle_gap();
		if (gap > 0 || !phase_open) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			if (!phase_open) begin
				@(posedge clk);
			end
		end
		phase_open = 1'b1;
		in_valid <= 1'b1;
		range_low <= lo;
		range_high <= hi;
		sample_value <= val;
		previous_pattern <= prev;
		do begin
			@(posedge clk);
		end while (!in_ready);
		pending_patterns.push_back(typed ? result : predict_pattern(lo, hi, val, prev));
	endtask

	task automatic random_request();
		logic [63:0] vb;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] prev;
		real v;
		real w;
		real lr;
		real hr;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			send_request(rand64(), rand64(), rand64(), rand64(), 1'b0, 64'd0);
			return;
		end
		vb = rand64();
		vb[62:52] = 11'($urandom_range(1013, 1033));
		v = $bitstoreal(vb);
		w = ((v < 0.0) ? -v : v) * (2.0 ** (-1.0 * $urandom_range(1, 45)));
		lr = v - w * $urandom_range(0, 100) / 100.0;
		hr = v + w * $urandom_range(0, 100) / 100.0;
		if (pick < 35) begin
			if (v > 0.0) begin
				lr = -hr * $urandom_range(1, 200) / 100.0;
			end else begin
				hr = -lr * $urandom_range(1, 200) / 100.0;
			end
		end else if (pick < 40) begin
			lr = hr;
		end
		lo = $realtobits(lr);
		hi = $realtobits(hr);
		case ($urandom_range(0, 2))
			0: prev = vb ^ (rand64() & (ALL_ONES >> $urandom_range(0, 63)));
			1: prev = lo ^ (rand64() & (ALL_ONES >> $urandom_range(8, 63)));
			default: prev = rand64();
		endcase
		send_request(lo, hi, vb, prev, 1'b0, 64'd0);
	endtask

	// Receiver: accept results with random stretches of backpressure.
	initial begin
		int stall;
		stall = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (pending_patterns.size() == 0) begin
					$error("approx_pattern: unexpected result %h", approx_pattern);
					fails++;
				end else begin
					logic [63:0] exp_pat;
					exp_pat = pending_patterns.pop_front();
					if (approx_pattern !== exp_pat) begin
						$error("approx_pattern: expected %h, actual %h", exp_pat, approx_pattern);
						fails++;
					end
				end
			end
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else begin
				stall = idle_gap();
				out_ready <= (stall == 0);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		probe_row_t rows[$];
		logic [63:0] phase_bound[5];
		logic [63:0] phase_offset[5];
		fails = 0;
		quiet_cycles = 0;
		no_idle = 1'b0;
		phase_open = 1'b0;
		bound_bits = 64'd0;
		offset_bits = 64'd0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_ERROR_BOUND;
		cfg_data = 64'd0;
		in_valid = 1'b0;
		range_low = 64'd0;
		range_high = 64'd0;
		sample_value = 64'd0;
		previous_pattern = 64'd0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		rows = '{
			'{64'h3ff0000000000000, 64'h3ff0000000000000, 64'h3ff0000000000000,
				64'h0, 1'b1, 64'h3ff0000000000000},
			'{64'h7ff8000000000001, 64'hfff8000000000001, 64'h3ff0000000000000,
				64'h0, 1'b1, 64'h3ff0000000000000},
			'{64'h0, 64'h0, 64'h0, 64'h0, 1'b1, 64'h0},
			'{ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1'b0, 64'h0},
			'{64'hc000000000000000, 64'hbff0000000000000, 64'hbff8000000000000,
				64'h1234567890abcdef, 1'b0, 64'h0},
			'{64'hbff0000000000000, 64'h3ff0000000000000, 64'hbfe0000000000000,
				64'h0, 1'b0, 64'h0},
			'{SIGN_BIT, 64'h0, 64'h0, ALL_ONES, 1'b0, 64'h0},
			'{64'h4000000000000000, 64'h3ff0000000000000, 64'h3ff8000000000000,
				64'h0, 1'b0, 64'h0},
			'{64'hfff0000000000000, 64'h7ff0000000000000, 64'h0, 64'h0, 1'b0, 64'h0},
			'{64'h3ff0000000000000, 64'h4000000000000000, 64'h3ff8000000000000,
				ALL_ONES, 1'b0, 64'h0},
			'{64'h1, 64'h3, 64'h2, 64'h0, 1'b0, 64'h0},
			'{64'h0, 64'h7fefffffffffffff, 64'h7fefffffffffffff, MAG_MASK, 1'b0, 64'h0},
			'{64'h3ff0000000000000, 64'h3ff0000000000fff, 64'h3ff0000000000800,
				64'h3ff00000000007ff, 1'b0, 64'h0}
		};
		foreach (rows[i]) begin
			send_request(rows[i].lo, rows[i].hi, rows[i].val, rows[i].prev,
				rows[i].typed, rows[i].result);
		end

		phase_bound = '{64'h3ff0000000000000, 64'h7ff0000000000000, ALL_ONES,
			64'h3f50624dd2f1a9fc, 64'h0};
		phase_offset = '{64'h3ff8000000000000, 64'hbff0000000000000, ALL_ONES,
			64'h0, 64'h0};
		for (int p = 0; p < PHASE_COUNT; p++) begin
			drain();
			phase_open = 1'b0;
			if (p < 5) begin
				write_reg(CFG_ERROR_BOUND, phase_bound[p]);
				write_reg(CFG_ADJUST_OFFSET, phase_offset[p]);
			end else begin
				write_reg(CFG_ERROR_BOUND, $realtobits(10.0 ** (-1.0 * $urandom_range(0, 14))));
				write_reg(CFG_ADJUST_OFFSET, ($urandom_range(0, 1) == 0) ? 64'd0 :
					$realtobits($urandom_range(0, 1000) / 256.0 - 2.0));
			end
			no_idle = (p % 4 == 3);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				random_request();
			end
		end
		drain();

		if (fails == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
`default_nettype wire

FILE: bounded_bit_pattern_search_top.f
rtl/bbps_pkg.sv
rtl/bbps_fadd.sv
rtl/bbps_dp.sv
rtl/bbps_ctrl.sv
rtl/bounded_bit_pattern_search_top.sv
rtl/bbps_checker.sv
verif/tb.sv
